>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion, disabled while the active-low reset is asserted
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

>>> rtl/gkcp_pkg.sv
// package for the k-core peeler: sizes, codes, state enum
// no dependencies
`timescale 1ns / 1ps
package gkcp_pkg;
    localparam int MaxVertices = 1024;
    localparam int MaxEntries  = 4096;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEntries);

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_CLOSE  = 3'd2;
    localparam logic [2:0] OP_RUN    = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_READ_WAIT,
        S_SEED_RD, S_SEED_WAIT, S_SEED,
        S_POP, S_POP_WAIT, S_BOUNDS,
        S_EDGE_RD, S_EDGE_WAIT, S_DEG_WAIT, S_DEG,
        S_OUT
    } t_state;
endpackage

>>> rtl/gkcp_ram.sv
// generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module gkcp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> rtl/graph_k_core_peeler.sv
// k-core peeler top level: load, peel sequencer, removed-list reads
// depends on gkcp_pkg and gkcp_ram
`timescale 1ns / 1ps
// one transaction in, one transaction out. clear and the unused operation codes
// answer in the cycle after the input is taken; append and close answer via
// S_BOUNDS, a read via S_READ_WAIT (it addresses the removed-list ram straight
// from the input). a run uses one degree compare/decrement unit and ram reads:
// per seeded vertex S_SEED_RD, S_SEED_WAIT, S_SEED; per popped vertex S_POP,
// S_POP_WAIT and an offset fetch; per list entry S_EDGE_RD, S_EDGE_WAIT,
// S_DEG_WAIT, S_DEG (no S_DEG for a foreign neighbor). the block takes no new
// transaction until its result has been taken. no clearing pass after reset.
module graph_k_core_peeler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,    // core_threshold
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // operation[2:0], neighbor_id[12:3], read_index[22:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[1:0], value[12:2]
);
    localparam int VW = gkcp_pkg::VW;
    localparam int EW = gkcp_pkg::EW;

    gkcp_pkg::t_state r_state, n_state;

    logic [12:0]   r_k;
    logic [VW:0]   r_vcnt, n_vcnt;
    logic [EW:0]   r_ecnt, n_ecnt;
    logic [VW:0]   r_rcnt, n_rcnt;
    logic [VW:0]   r_sp, n_sp;
    logic [VW:0]   r_v, n_v;          // seed walk index
    logic [VW-1:0] r_cur, n_cur;      // popped vertex
    logic [EW:0]   r_e, n_e, r_end, n_end;
    logic [VW-1:0] r_nb, n_nb;
    logic [EW:0]   r_prev, n_prev;    // end offset of previous vertex
    logic [1:0]    r_st, n_st;
    logic [10:0]   r_val, n_val;
    logic [2:0]    r_op;
    logic [VW-1:0] r_nid, r_idx;

    // ram ports
    logic          nb_we;  logic [EW-1:0] nb_wa, nb_ra; logic [VW-1:0] nb_rd;
    logic          lo_we;  logic [VW-1:0] lo_wa, lo_ra; logic [EW:0]  lo_wd, lo_rd;
    logic          wd_we;  logic [VW-1:0] wd_wa, wd_ra; logic [12:0]  wd_wd, wd_rd;
    logic          sk_we;  logic [VW-1:0] sk_wa, sk_ra, sk_wd, sk_rd;
    logic          rm_we;  logic [VW-1:0] rm_wa, rm_ra, rm_wd, rm_rd;

    gkcp_ram #(.Width(VW), .Depth(gkcp_pkg::MaxEntries)) u_nbr (
        .i_clk, .i_we(nb_we), .i_waddr(nb_wa), .i_wdata(r_nid),
        .i_raddr(nb_ra), .o_rdata(nb_rd));
    gkcp_ram #(.Width(EW+1), .Depth(gkcp_pkg::MaxVertices)) u_end (
        .i_clk, .i_we(lo_we), .i_waddr(lo_wa), .i_wdata(lo_wd),
        .i_raddr(lo_ra), .o_rdata(lo_rd));
    gkcp_ram #(.Width(13), .Depth(gkcp_pkg::MaxVertices)) u_deg (
        .i_clk, .i_we(wd_we), .i_waddr(wd_wa), .i_wdata(wd_wd),
        .i_raddr(wd_ra), .o_rdata(wd_rd));
    gkcp_ram #(.Width(VW), .Depth(gkcp_pkg::MaxVertices)) u_stk (
        .i_clk, .i_we(sk_we), .i_waddr(sk_wa), .i_wdata(sk_wd),
        .i_raddr(sk_ra), .o_rdata(sk_rd));
    gkcp_ram #(.Width(VW), .Depth(gkcp_pkg::MaxVertices)) u_rem (
        .i_clk, .i_we(rm_we), .i_waddr(rm_wa), .i_wdata(rm_wd),
        .i_raddr(rm_ra), .o_rdata(rm_rd));

    assign s_axis_tready = (r_state == gkcp_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == gkcp_pkg::S_OUT);
    assign m_axis_tdata  = {3'd0, r_val, r_st};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gkcp_pkg::S_IDLE;
            r_k     <= '0;
            r_vcnt  <= '0;
            r_ecnt  <= '0;
            r_rcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_vcnt  <= n_vcnt;
            r_ecnt  <= n_ecnt;
            r_rcnt  <= n_rcnt;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
        end
        // payload and walk registers
        r_sp <= n_sp; r_v <= n_v; r_cur <= n_cur; r_e <= n_e; r_end <= n_end;
        r_nb <= n_nb; r_prev <= n_prev; r_st <= n_st; r_val <= n_val;
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= s_axis_tdata[2:0];
            r_nid <= s_axis_tdata[12:3];
            r_idx <= s_axis_tdata[22:13];
        end
    end

    // degree compare against k and decrement for the neighbor update
    logic deg_ge_k;
    logic [12:0] deg_dec;
    assign deg_ge_k = (wd_rd >= r_k);
    assign deg_dec  = wd_rd - 13'd1;

    always_comb begin
        n_state = r_state;
        n_vcnt = r_vcnt; n_ecnt = r_ecnt; n_rcnt = r_rcnt; n_sp = r_sp;
        n_v = r_v; n_cur = r_cur; n_e = r_e; n_end = r_end; n_nb = r_nb;
        n_prev = r_prev; n_st = r_st; n_val = r_val;
        nb_we = 1'b0; nb_wa = r_ecnt[EW-1:0]; nb_ra = r_e[EW-1:0];
        lo_we = 1'b0; lo_wa = r_vcnt[VW-1:0]; lo_wd = r_ecnt; lo_ra = r_cur;
        wd_we = 1'b0; wd_wa = r_nb; wd_wd = deg_dec; wd_ra = r_nb;
        sk_we = 1'b0; sk_wa = r_sp[VW-1:0]; sk_wd = r_nb; sk_ra = r_sp[VW-1:0] - 1'b1;
        rm_we = 1'b0; rm_wa = r_rcnt[VW-1:0]; rm_ra = r_idx; rm_wd = r_cur;
        unique case (r_state)
            gkcp_pkg::S_IDLE: begin
                // removed-list read addressed from the incoming transaction
                rm_ra = s_axis_tdata[22:13];
                if (s_axis_tvalid) begin
                    n_state = gkcp_pkg::S_OUT;
                    n_st = gkcp_pkg::ST_OK;
                    n_val = '0;
                    unique case (s_axis_tdata[2:0])
                        gkcp_pkg::OP_CLEAR: begin
                            n_vcnt = '0; n_ecnt = '0; n_rcnt = '0;
                        end
                        gkcp_pkg::OP_APPEND, gkcp_pkg::OP_CLOSE: begin
                            n_state = gkcp_pkg::S_BOUNDS;  // commit next cycle
                        end
                        gkcp_pkg::OP_RUN: begin
                            n_rcnt = '0; n_sp = '0; n_v = '0; n_prev = '0;
                            n_state = gkcp_pkg::S_SEED_RD;
                        end
                        gkcp_pkg::OP_READ: begin
                            n_state = gkcp_pkg::S_READ_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            gkcp_pkg::S_READ_WAIT: begin
                if ({1'b0, r_idx} >= r_rcnt) begin
                    n_st = gkcp_pkg::ST_RANGE;
                end else begin
                    n_val = {1'b0, rm_rd};
                end
                n_state = gkcp_pkg::S_OUT;
            end
            gkcp_pkg::S_SEED_RD: begin
                lo_ra = r_v[VW-1:0];
                if (r_v >= r_vcnt) begin
                    n_state = gkcp_pkg::S_POP;
                end else begin
                    n_state = gkcp_pkg::S_SEED_WAIT;
                end
            end
            gkcp_pkg::S_SEED_WAIT: begin
                // keep the end offset address so the read data still holds in S_SEED
                lo_ra = r_v[VW-1:0];
                n_state = gkcp_pkg::S_SEED;
            end
            gkcp_pkg::S_SEED: begin
                wd_we = 1'b1;
                wd_wa = r_v[VW-1:0];
                wd_wd = 13'(lo_rd - r_prev);
                if (13'(lo_rd - r_prev) < r_k) begin
                    sk_we = 1'b1;
                    sk_wd = r_v[VW-1:0];
                    n_sp = r_sp + 1'b1;
                end
                n_prev = lo_rd;
                n_v = r_v + 1'b1;
                n_state = gkcp_pkg::S_SEED_RD;
            end
            gkcp_pkg::S_POP: begin
                if (r_sp == '0) begin
                    n_val = 11'(r_rcnt);
                    n_state = gkcp_pkg::S_OUT;
                end else begin
                    n_sp = r_sp - 1'b1;
                    n_state = gkcp_pkg::S_POP_WAIT;
                end
            end
            gkcp_pkg::S_POP_WAIT: begin
                // stack read lands: log vertex as removed, then fetch end and previous end
                n_cur = sk_rd;
                rm_we = 1'b1;
                rm_wa = r_rcnt[VW-1:0];
                rm_wd = sk_rd;
                n_rcnt = r_rcnt + 1'b1;
                n_e = '0;
                n_state = gkcp_pkg::S_EDGE_RD;   // reuse to read offsets
                n_end = '1;
            end
            gkcp_pkg::S_EDGE_RD: begin
                if (r_end == '1 && r_e == '0) begin
                    // offset fetch phase: read end of cur-1 first
                    lo_ra = r_cur - 1'b1;
                    n_e = '1;
                    n_state = gkcp_pkg::S_EDGE_WAIT;
                end else if (r_e >= r_end) begin
                    n_state = gkcp_pkg::S_POP;
                end else begin
                    nb_ra = r_e[EW-1:0];
                    n_state = gkcp_pkg::S_EDGE_WAIT;
                end
            end
            gkcp_pkg::S_EDGE_WAIT: begin
                if (r_end == '1) begin
                    // start offset arrives; request end offset
                    n_e = (r_cur == '0) ? '0 : lo_rd;
                    lo_ra = r_cur;
                    n_state = gkcp_pkg::S_BOUNDS;
                end else begin
                    n_state = gkcp_pkg::S_DEG_WAIT;
                end
            end
            gkcp_pkg::S_BOUNDS: begin
                if (r_op == gkcp_pkg::OP_APPEND) begin
                    if (r_ecnt >= (EW+1)'(gkcp_pkg::MaxEntries) ||
                        r_vcnt >= (VW+1)'(gkcp_pkg::MaxVertices)) begin
                        n_st = gkcp_pkg::ST_FULL;
                    end else begin
                        nb_we = 1'b1;
                        n_ecnt = r_ecnt + 1'b1;
                    end
                    n_state = gkcp_pkg::S_OUT;
                end else if (r_op == gkcp_pkg::OP_CLOSE) begin
                    if (r_vcnt >= (VW+1)'(gkcp_pkg::MaxVertices)) begin
                        n_st = gkcp_pkg::ST_FULL;
                    end else begin
                        lo_we = 1'b1;
                        n_vcnt = r_vcnt + 1'b1;
                    end
                    n_state = gkcp_pkg::S_OUT;
                end else begin
                    // run: end offset read data lands next cycle
                    lo_ra = r_cur;
                    n_state = gkcp_pkg::S_DEG;
                    n_nb = '0;
                    n_end = '0;
                end
            end
            gkcp_pkg::S_DEG_WAIT: begin
                // neighbor id available; read its degree
                n_nb = nb_rd;
                wd_ra = nb_rd;
                n_end = r_end;
                n_state = ({1'b0, nb_rd} >= r_vcnt) ? gkcp_pkg::S_EDGE_RD : gkcp_pkg::S_DEG;
                n_e = r_e + 1'b1;
                n_nb = nb_rd;
                n_cur = r_cur;
                if ({1'b0, nb_rd} < r_vcnt) begin
                    n_e = r_e;
                end
            end
            gkcp_pkg::S_DEG: begin
                if (r_end == '0) begin
                    // end offset from S_BOUNDS arrives
                    n_end = lo_rd;
                    n_state = gkcp_pkg::S_EDGE_RD;
                end else begin
                    // compare/decrement on neighbor degree
                    if (deg_ge_k) begin
                        wd_we = 1'b1;
                        if (deg_dec < r_k) begin
                            sk_we = 1'b1;
                            n_sp = r_sp + 1'b1;
                        end
                    end
                    n_e = r_e + 1'b1;
                    n_state = gkcp_pkg::S_EDGE_RD;
                end
            end
            gkcp_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    n_state = gkcp_pkg::S_IDLE;
                end
            end
            default: n_state = gkcp_pkg::S_IDLE;
        endcase
    end
endmodule

>>> rtl/gkcp_checker.sv
// port-level checker for the k-core peeler, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gkcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `CHK_ASSERT(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready, "busy while result waits")
    `CHK_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed under stall")
    `CHK_ASSERT(a_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "accepted twice")
    `CHK_ASSERT(a_status, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3, "bad status")
endmodule

bind graph_k_core_peeler gkcp_checker u_gkcp_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

>>> bench/gkcp_checker.sv
// checker for the k-core peeler: predicts every result and compares it
// depends on gkcp_pkg; watches the config port and both stream channels
`timescale 1ns / 1ps
module gkcp_scoreboard
    import gkcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] value;
    } answer_t;

    answer_t     answer_q[$];
    logic [12:0] k_bound;
    logic [9:0]  nbr_store[MaxEntries];
    logic [12:0] list_end[MaxVertices];
    logic [12:0] degree[MaxVertices];
    logic [9:0]  peel_stack[MaxVertices];
    logic [9:0]  removed[MaxVertices];
    int          vcount;
    int          ecount;
    int          removed_n;

    function automatic int list_begin(int v);
        return (v == 0) ? 0 : int'(list_end[v - 1]);
    endfunction

    function automatic void peel_graph();
        int sp;
        int cur;
        int n;
        sp = 0;
        removed_n = 0;
        for (int v = 0; v < vcount; v++) begin
            degree[v] = 13'(int'(list_end[v]) - list_begin(v));
            if (degree[v] < k_bound) begin
                peel_stack[sp] = 10'(v);
                sp++;
            end
        end
        while (sp > 0) begin
            sp--;
            cur = int'(peel_stack[sp]);
            removed[removed_n] = 10'(cur);
            removed_n++;
            for (int e = list_begin(cur); e < int'(list_end[cur]); e++) begin
                n = int'(nbr_store[e]);
                if (n < vcount && degree[n] >= k_bound) begin
                    degree[n] = degree[n] - 13'd1;
                    if (degree[n] < k_bound) begin
                        peel_stack[sp] = 10'(n);
                        sp++;
                    end
                end
            end
        end
    endfunction

    function automatic answer_t core_answer(logic [2:0] op, logic [9:0] nid, logic [9:0] idx);
        answer_t a;
        a = '0;
        a.status = ST_OK;
        case (op)
            OP_CLEAR: begin
                vcount = 0;
                ecount = 0;
                removed_n = 0;
            end
            OP_APPEND: begin
                if (ecount >= MaxEntries || vcount >= MaxVertices) begin
                    a.status = ST_FULL;
                end else begin
                    nbr_store[ecount] = nid;
                    ecount++;
                end
            end
            OP_CLOSE: begin
                if (vcount >= MaxVertices) begin
                    a.status = ST_FULL;
                end else begin
                    list_end[vcount] = 13'(ecount);
                    vcount++;
                end
            end
            OP_RUN: begin
                peel_graph();
                a.value = 11'(removed_n);
            end
            OP_READ: begin
                if (int'(idx) >= removed_n) a.status = ST_RANGE;
                else a.value = {1'b0, removed[idx]};
            end
            default: ;
        endcase
        return a;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        answer_t got;
        answer_t want;
        if (!i_rst_n) begin
            answer_q.delete();
            k_bound <= '0;
            vcount = 0;
            ecount = 0;
            removed_n = 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) k_bound <= i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                answer_q = {answer_q, core_answer(i_in_data[2:0], i_in_data[12:3],
                                                  i_in_data[22:13])};
            if (i_out_valid && i_out_ready) begin
                got.status = i_out_data[1:0];
                got.value = i_out_data[12:2];
                if (answer_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result status %0d value %0d",
                                 $realtime, got.status, got.value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch status exp %0d got %0d, value exp %0d got %0d",
                                     $realtime, want.status, got.status, want.value, got.value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/tb.sv
// testbench top for the k-core peeler: stimulus, handshake pacing, verdict
// depends on gkcp_pkg, graph_k_core_peeler and gkcp_scoreboard
`timescale 1ns / 1ps
module tb;
    import gkcp_pkg::*;

    localparam int WatchLimit = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [12:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // operation[2:0], neighbor_id[12:3], read_index[22:13]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status[1:0], value[12:2]
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          long_hold;
    int          quiet_cycles;
    int          item_count;

    graph_k_core_peeler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    gkcp_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("FAIL graph_k_core_peeler");
            $finish;
        end
    end

    // one input transaction; valid stays high from item to item unless idling
    task automatic send_item(int op, int nid, int idx);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, 10'(idx), 10'(nid), 3'(op)};
        do @(posedge i_clk); while (!s_axis_tready);
        item_count++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // threshold writes only once the block has gone quiet
    task automatic set_threshold(int k);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 13'(k);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // clear, load a small graph, peel it, then read back the removed list
    task automatic graph_round();
        int nv;
        int deg;
        nv = $urandom_range(1, 12);
        send_item(OP_CLEAR, $urandom, $urandom);
        for (int v = 0; v < nv; v++) begin
            deg = $urandom_range(0, 5);
            for (int d = 0; d < deg; d++) begin
                if ($urandom_range(99) < 85) send_item(OP_APPEND, $urandom_range(0, nv - 1), $urandom);
                else send_item(OP_APPEND, $urandom, $urandom);
            end
            // noise: items with unused operation codes
            if ($urandom_range(99) < 10) send_item($urandom_range(5, 7), $urandom, $urandom);
            send_item(OP_CLOSE, $urandom, $urandom);
        end
        if ($urandom_range(99) < 15) send_item(OP_APPEND, $urandom, $urandom);
        send_item(OP_RUN, $urandom, $urandom);
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(99) < 12) send_item(OP_READ, $urandom, $urandom);
            else send_item(OP_READ, $urandom, $urandom_range(0, nv + 1));
        end
        if ($urandom_range(99) < 10) send_item($urandom_range(0, 7), $urandom, $urandom);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 0;
        quiet_cycles = 0;
        item_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty graph, threshold zero, out-of-range reads, unused codes
        send_item(OP_RUN, 0, 0);
        send_item(OP_READ, 0, 0);
        send_item(OP_READ, 0, 10'h3ff);
        send_item(3'd5, 10'h3ff, 10'h3ff);
        send_item(3'd7, 0, 0);
        // self loop, repeated and foreign neighbors, extremes of the id
        send_item(OP_APPEND, 10'd0, 0);
        send_item(OP_APPEND, 10'd1, 0);
        send_item(OP_APPEND, 10'd1, 0);
        send_item(OP_CLOSE, 0, 0);
        send_item(OP_APPEND, 10'h3ff, 0);
        send_item(OP_APPEND, 10'd0, 0);
        send_item(OP_CLOSE, 0, 0);
        send_item(OP_CLOSE, 0, 0);
        send_item(OP_APPEND, 10'd2, 0);   // unclosed entry, ignored by a run
        send_item(OP_RUN, 0, 0);          // threshold still zero: nothing removed
        set_threshold(2);
        send_item(OP_RUN, 0, 0);
        send_item(OP_READ, 0, 10'd0);
        send_item(OP_READ, 0, 10'd1);
        send_item(OP_READ, 0, 10'd3);
        set_threshold(4096);
        send_item(OP_RUN, 0, 0);
        send_item(OP_READ, 0, 10'd2);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_READ, 0, 10'd0);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_threshold(1);
                1: set_threshold(0);
                2: set_threshold(4096);
                default: set_threshold($urandom_range(2, 4));
            endcase
            send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 30 : 0;
            recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 30 : 0;
            if (ph == 2) long_hold = 300;   // sender keeps offering, block backs up
            item_count = 0;
            while (item_count < 225) begin
                graph_round();
                if (ph == 3 && $urandom_range(99) < 20) set_threshold($urandom_range(0, 6));
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS graph_k_core_peeler");
        else
            $display("FAIL graph_k_core_peeler");
        $finish;
    end
endmodule
